// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the binary gas diffusivity block.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the synchronous reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- design/bgd_pkg.sv -----
// Package of the binary gas diffusivity block: payload types, source codes,
// configuration indexes, fixed-point coefficients and lookup tables. No dependencies.
`default_nettype none

package bgd_pkg;

    localparam int DIFF_W = 48;

    typedef struct packed {
        logic [15:0]        zone_id;
        logic [2:0]         species;
        logic [19:0]        temperature;
        logic signed [31:0] gauge_pressure;
    } t_in;

    typedef enum logic [1:0] {
        SRC_SUPPRESSED = 2'd0,
        SRC_FALLBACK   = 2'd1,
        SRC_COMPUTED   = 2'd2
    } t_source;

    typedef struct packed {
        logic [DIFF_W-1:0] diffusivity;
        t_source           source;
    } t_out;

    // Configuration register indexes.
    localparam logic CFG_OPERATING_PRESSURE = 1'b0;
    localparam logic CFG_SUPPRESSED_ZONE    = 1'b1;

    localparam logic [23:0] OP_PRESSURE_RESET = 24'd100000;
    localparam logic [15:0] SUPP_ZONE_RESET   = 16'd6;

    // Trusted temperature window in 1/16 K and the lowest trusted pressure in Pa.
    localparam logic [19:0]        T_MIN = 20'd4800;
    localparam logic [19:0]        T_MAX = 20'd80000;
    localparam logic signed [32:0] P_MIN = 33'sd10000;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    // Neufeld collision integral coefficients in Q16; exponent ones carry log2(e).
    localparam logic [16:0] NF_A  = 17'd69492;
    localparam logic [13:0] NF_B  = 14'd10230;
    localparam logic [16:0] NF_C  = 17'd12648;
    localparam logic [16:0] NF_E  = 17'd67887;
    localparam logic [16:0] NF_G  = 17'd115654;
    localparam logic [15:0] NF_DL = 16'd45038;
    localparam logic [17:0] NF_FL = 18'd144655;
    localparam logic [18:0] NF_HL = 19'd368178;

    // log2(1 + k/16) in Q16.
    function automatic logic [16:0] log2_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // 2^-(k/16) in Q16.
    function automatic logic [16:0] exp2n_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52772;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Well depth of the pair against N2 times 256. Unknown species get a
    // large divisor; their quotient is never used.
    function automatic logic [15:0] eps_q8(input logic [2:0] sp);
        logic [15:0] v;
        case (sp)
            3'd0:    v = 16'd47442;
            3'd1:    v = 16'd18278;
            3'd2:    v = 16'd16714;
            3'd3:    v = 16'd22345;
            default: v = 16'hFFFF;
        endcase
        return v;
    endfunction

    // Species constant of the Chapman-Enskog relation in Q32.
    function automatic logic [22:0] k_q32(input logic [2:0] sp);
        logic [22:0] v;
        case (sp)
            3'd0:    v = 23'd1717899;
            3'd1:    v = 23'd1478163;
            3'd2:    v = 23'd5303197;
            3'd3:    v = 23'd1564809;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/binary_gas_diffusivity.sv -----
// Top level of the binary gas diffusivity block: input decode, square root and
// division pipelines, output skid. Depends on bgd_pkg, bgd_omega, assert_macros.svh.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in_data  (t_in)
//  out      | output    | o_out_valid / i_out_ready| o_out_data (t_out)
//  cfg      | input     | i_cfg_we (write only)    | i_cfg_index, i_cfg_data
//
// One transaction enters per cycle while the skid register is free; its path
// runs through the 49-step restoring division of the final quotient, the
// 23-step reduced temperature division and the six-stage collision integral.
// Reset is synchronous and active low; it clears the valid bits and loads the
// configuration defaults. A stalled output freezes the pipeline only once the
// skid register also holds a result, so no transaction is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module binary_gas_diffusivity
    import bgd_pkg::*;
#(
    parameter int OUTPUT_FRAC_BITS = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    // The product of species constant and T^1.5 is scaled by 2^(F-31), one bit
    // beyond the output scale, so that rounding half up is a final add and shift.
    localparam int SHIFT   = OUTPUT_FRAC_BITS - 31;
    localparam int NUM_W   = 59;
    localparam int DIV_W   = NUM_W + SHIFT;
    localparam int QB      = DIFF_W + 1;
    localparam int DEN_W   = 49;
    localparam int SQ_STEPS = 19;
    localparam int TS_STEPS = 23;
    localparam int B_DEPTH = 6;

    localparam logic [63:0] FB_FULL =
        ((64'd2 << OUTPUT_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [DIFF_W-1:0] FALLBACK = FB_FULL[DIFF_W-1:0];

    // Square root of T<<20 and the reduced temperature division run side by side.
    typedef struct packed {
        logic        v;
        t_source     src;
        logic [1:0]  sp;
        logic [31:0] pabs;
        logic [16:0] t17;
        logic [18:0] root;
        logic [36:0] srem;
        logic [22:0] tsq;
        logic [15:0] tsrem;
        logic [15:0] eps;
    } t_lane_a;

    // Transactions wait here for the collision integral.
    typedef struct packed {
        logic        v;
        t_source     src;
        logic [1:0]  sp;
        logic [31:0] pabs;
        logic [35:0] t15;
    } t_lane_b;

    typedef struct packed {
        logic             v;
        t_source          src;
        logic [DEN_W-1:0] den;
        logic [40:0]      pp_lo;
        logic [40:0]      pp_hi;
    } t_lane_c;

    typedef struct packed {
        logic             v;
        t_source          src;
        logic             sat;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    low;
        logic [QB-1:0]    q;
    } t_lane_d;

    logic        en;
    logic        accept;
    logic [23:0] r_op;
    logic [15:0] r_supp;

    t_lane_a r_a [TS_STEPS+1];
    t_lane_b r_b [B_DEPTH];
    t_lane_c r_c;
    t_lane_d r_d [QB+1];

    t_out r_out;
    logic r_out_v;
    t_out r_skid;
    logic r_skid_v;
    logic take;

    // The pipeline moves whenever the skid register is free.
    assign en         = !r_skid_v;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_PRESSURE_RESET;
            r_supp <= SUPP_ZONE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OPERATING_PRESSURE: r_op   <= i_cfg_data;
                CFG_SUPPRESSED_ZONE:    r_supp <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Entry: absolute pressure and the choice of result source are settled
    // here, so later stages only carry the code.
    logic signed [32:0] pabs_s;
    t_lane_a            n_a0;

    always_comb begin
        pabs_s = {i_in_data.gauge_pressure[31], i_in_data.gauge_pressure}
               + $signed({9'd0, r_op});
        n_a0 = '0;
        n_a0.v = accept;
        if (i_in_data.zone_id == r_supp) begin
            n_a0.src = SRC_SUPPRESSED;
        end else if (i_in_data.temperature < T_MIN || i_in_data.temperature > T_MAX
                     || pabs_s < P_MIN || i_in_data.species[2]) begin
            n_a0.src = SRC_FALLBACK;
        end else begin
            n_a0.src = SRC_COMPUTED;
        end
        n_a0.sp    = i_in_data.species[1:0];
        n_a0.pabs  = pabs_s[31:0];
        // Only temperatures up to 80000 reach the formula, so 17 bits suffice.
        n_a0.t17   = i_in_data.temperature[16:0];
        n_a0.srem  = {i_in_data.temperature[16:0], 20'd0};
        n_a0.tsrem = 16'(i_in_data.temperature[16:3]);
        n_a0.eps   = eps_q8(i_in_data.species);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a[0].v <= 1'b0;
        end else if (en) begin
            r_a[0] <= n_a0;
        end
    end

    // Lane A: one root bit per stage until the root is complete, and one quotient bit in every stage.
    for (genvar s = 0; s < TS_STEPS; s++) begin : g_a
        localparam int QI = TS_STEPS - 1 - s;
        logic [18:0] root_n;
        logic [36:0] srem_n;
        logic [22:0] tsq_n;
        logic [15:0] tsrem_n;
        logic        dbit;
        logic [16:0] rr;
        t_lane_a     n_a;

        if (s < SQ_STEPS) begin : g_sq
            localparam int B = SQ_STEPS - 1 - s;
            logic [37:0] trial;
            always_comb begin
                trial = (38'(r_a[s].root) << (B + 1)) + (38'd1 << (2 * B));
                if ({1'b0, r_a[s].srem} >= trial) begin
                    srem_n = 37'({1'b0, r_a[s].srem} - trial);
                    root_n = r_a[s].root | (19'd1 << B);
                end else begin
                    srem_n = r_a[s].srem;
                    root_n = r_a[s].root;
                end
            end
        end else begin : g_sq_hold
            assign root_n = r_a[s].root;
            assign srem_n = r_a[s].srem;
        end

        // The dividend is T<<20; only its top three low bits are nonzero.
        if (QI >= 20) begin : g_db
            assign dbit = r_a[s].t17[QI-20];
        end else begin : g_dz
            assign dbit = 1'b0;
        end

        always_comb begin
            rr = {r_a[s].tsrem, dbit};
            if (rr >= 17'(r_a[s].eps)) begin
                tsrem_n = 16'(rr - 17'(r_a[s].eps));
                tsq_n   = r_a[s].tsq | (23'd1 << QI);
            end else begin
                tsrem_n = rr[15:0];
                tsq_n   = r_a[s].tsq;
            end
            n_a       = r_a[s];
            n_a.root  = root_n;
            n_a.srem  = srem_n;
            n_a.tsq   = tsq_n;
            n_a.tsrem = tsrem_n;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a[s+1].v <= 1'b0;
            end else if (en) begin
                r_a[s+1] <= n_a;
            end
        end
    end

    // Collision integral of the reduced temperature, aligned with lane B.
    logic [16:0] om;

    bgd_omega u_omega (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ts  (r_a[TS_STEPS].tsq),
        .o_om  (om)
    );

    // Lane B: T^1.5 in Q16, then wait for the collision integral.
    t_lane_b n_b0;

    always_comb begin
        n_b0.v    = r_a[TS_STEPS].v;
        n_b0.src  = r_a[TS_STEPS].src;
        n_b0.sp   = r_a[TS_STEPS].sp;
        n_b0.pabs = r_a[TS_STEPS].pabs;
        n_b0.t15  = 36'(r_a[TS_STEPS].t17) * 36'(r_a[TS_STEPS].root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < B_DEPTH; i++) begin
                r_b[i].v <= 1'b0;
            end
        end else if (en) begin
            r_b[0] <= n_b0;
            for (int i = 1; i < B_DEPTH; i++) begin
                r_b[i] <= r_b[i-1];
            end
        end
    end

    // Stage C: denominator and the two halves of the numerator product.
    logic [22:0] kq;
    t_lane_c     n_c;

    always_comb begin
        kq        = k_q32({1'b0, r_b[B_DEPTH-1].sp});
        n_c.v     = r_b[B_DEPTH-1].v;
        n_c.src   = r_b[B_DEPTH-1].src;
        n_c.den   = DEN_W'(r_b[B_DEPTH-1].pabs) * DEN_W'(om);
        n_c.pp_lo = 41'(kq) * 41'(r_b[B_DEPTH-1].t15[17:0]);
        n_c.pp_hi = 41'(kq) * 41'(r_b[B_DEPTH-1].t15[35:18]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.v <= 1'b0;
        end else if (en) begin
            r_c <= n_c;
        end
    end

    // Stage D0: full dividend; a quotient of 2^QB or more saturates at once.
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] dvd;
    t_lane_d          n_d0;

    always_comb begin
        num      = NUM_W'(r_c.pp_lo) + (NUM_W'(r_c.pp_hi) << 18);
        dvd      = DIV_W'(num) << SHIFT;
        n_d0.v   = r_c.v;
        n_d0.src = r_c.src;
        n_d0.den = r_c.den;
        n_d0.sat = DEN_W'(dvd[DIV_W-1:QB]) >= r_c.den;
        n_d0.rem = DEN_W'(dvd[DIV_W-1:QB]);
        n_d0.low = dvd[QB-1:0];
        n_d0.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d[0].v <= 1'b0;
        end else if (en) begin
            r_d[0] <= n_d0;
        end
    end

    // Restoring division, one quotient bit per stage from the top.
    for (genvar i = 0; i < QB; i++) begin : g_d
        localparam int QI = QB - 1 - i;
        logic [DEN_W:0] rr;
        t_lane_d        n_d;

        always_comb begin
            rr  = {r_d[i].rem, r_d[i].low[QI]};
            n_d = r_d[i];
            if (rr >= {1'b0, r_d[i].den}) begin
                n_d.rem = DEN_W'(rr - {1'b0, r_d[i].den});
                n_d.q   = r_d[i].q | (QB'(1) << QI);
            end else begin
                n_d.rem = rr[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[i+1].v <= 1'b0;
            end else if (en) begin
                r_d[i+1] <= n_d;
            end
        end
    end

    // Rounding half up, saturation and the source select.
    logic [QB:0]       qr;
    logic [DIFF_W-1:0] comp;
    t_out              n_res;

    always_comb begin
        qr = (QB + 1)'(r_d[QB].q) + (QB + 1)'(1);
        if (r_d[QB].sat || qr[QB]) begin
            comp = DIFF_MAX;
        end else begin
            comp = qr[QB-1:1];
        end
        n_res.source = r_d[QB].src;
        case (r_d[QB].src)
            SRC_SUPPRESSED: n_res.diffusivity = '0;
            SRC_FALLBACK:   n_res.diffusivity = FALLBACK;
            default:        n_res.diffusivity = comp;
        endcase
    end

    // Output register plus skid register. A result that finds the output
    // register occupied and not taken parks in the skid register.
    assign take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_d[QB].v) begin
            if (!r_out_v || take) begin
                r_out   <= n_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= n_res;
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // The skid register only fills behind a waiting output register.
    `ASSERT_CLK(a_skid_behind_out, r_skid_v |-> r_out_v, "skid holds a result but output is empty")
    // Suppressed zone cells always flush to zero.
    `ASSERT_CLK(a_supp_zero, (r_out_v && r_out.source == SRC_SUPPRESSED) |-> (r_out.diffusivity == '0), "suppressed result is not zero")
    // Fallback cells always carry the fixed fallback value.
    `ASSERT_CLK(a_fallback_value, (r_out_v && r_out.source == SRC_FALLBACK) |-> (r_out.diffusivity == FALLBACK), "fallback result has wrong value")

endmodule

`default_nettype wire

// ----- design/bgd_omega.sv -----
// Six-stage pipeline for the Neufeld collision integral of a reduced temperature.
// Depends on bgd_pkg for coefficients and the log2 and 2^-x tables.
`default_nettype none

module bgd_omega
    import bgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [22:0] i_ts,
    output logic      [16:0] o_om
);

    localparam logic [16:0] C_TERM [4] = '{NF_A, NF_C, NF_E, NF_G};

    // Interpolated 2^-f mantissa for a Q16 fraction.
    function automatic logic [16:0] exp2_mant(input logic [15:0] f);
        logic [16:0] t0;
        logic [16:0] t1;
        logic [11:0] d;
        logic [23:0] p;
        t0 = exp2n_tab({1'b0, f[15:12]});
        t1 = exp2n_tab({1'b0, f[15:12]} + 5'd1);
        d  = 12'(t0 - t1);
        p  = 24'(d) * 24'(f[11:0]);
        return t0 - 17'(p[23:12]);
    endfunction

    // Stage 1: leading one of the clamped argument, and the linear exponents.
    logic [22:0] x1;
    logic [2:0]  sh1;
    logic [16:0] m1;
    logic [2:0]  r1_sh;
    logic [15:0] r1_f;
    logic [38:0] r1_pr2;
    logic [40:0] r1_pr3;
    logic [41:0] r1_pr4;

    always_comb begin
        x1  = (i_ts < 23'd65536) ? 23'd65536 : i_ts;
        sh1 = 3'd0;
        for (int i = 17; i < 23; i++) begin
            if (x1[i]) sh1 = 3'(i - 16);
        end
        m1 = 17'(x1 >> sh1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sh  <= sh1;
            r1_f   <= m1[15:0];
            r1_pr2 <= 39'(NF_DL) * 39'(i_ts);
            r1_pr3 <= 41'(NF_FL) * 41'(i_ts);
            r1_pr4 <= 42'(NF_HL) * 42'(i_ts);
        end
    end

    // Stage 2: table interpolation of log2.
    logic [16:0] lt0;
    logic [16:0] lt1;
    logic [24:0] lp;
    logic [18:0] l2;
    logic [18:0] r2_l;
    logic [25:0] r2_y [3];

    always_comb begin
        lt0 = log2_tab({1'b0, r1_f[15:12]});
        lt1 = log2_tab({1'b0, r1_f[15:12]} + 5'd1);
        lp  = 25'(13'(lt1 - lt0)) * 25'(r1_f[11:0]);
        l2  = 19'({r1_sh, 16'd0}) + 19'(lt0) + 19'(lp[24:12]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_l    <= l2;
            r2_y[0] <= 26'(r1_pr2[38:16]);
            r2_y[1] <= 26'(r1_pr3[40:16]);
            r2_y[2] <= r1_pr4[41:16];
        end
    end

    // Stage 3: exponent of the power-law term.
    logic [32:0] p3;
    logic [25:0] r3_y [4];

    assign p3 = 33'(NF_B) * 33'(r2_l);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_y[0] <= 26'(p3[32:16]);
            r3_y[1] <= r2_y[0];
            r3_y[2] <= r2_y[1];
            r3_y[3] <= r2_y[2];
        end
    end

    // Stage 4: 2^-fraction mantissas and the integer shift of each term.
    logic [16:0] r4_m  [4];
    logic [4:0]  r4_sh [4];
    logic        r4_z  [4];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r4_m[j]  <= exp2_mant(r3_y[j][15:0]);
                r4_sh[j] <= r3_y[j][20:16];
                r4_z[j]  <= |r3_y[j][25:21];
            end
        end
    end

    // Stage 5: scale each term by its coefficient.
    logic [16:0] e5 [4];
    logic [33:0] r5_p [4];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            e5[j] = r4_z[j] ? 17'd0 : (r4_m[j] >> r4_sh[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r5_p[j] <= 34'(C_TERM[j]) * 34'(e5[j]);
            end
        end
    end

    // Stage 6: sum and clamp.
    logic [19:0] sum6;
    logic [16:0] r6_om;

    always_comb begin
        sum6 = '0;
        for (int j = 0; j < 4; j++) begin
            sum6 = sum6 + 20'(r5_p[j][33:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (sum6 == 20'd0) begin
                r6_om <= 17'd1;
            end else if (sum6 > 20'd131071) begin
                r6_om <= 17'd131071;
            end else begin
                r6_om <= sum6[16:0];
            end
        end
    end

    assign o_om = r6_om;

endmodule

`default_nettype wire

// ----- tb/sv/binary_gas_diffusivity_tb.sv -----
// Self-checking testbench of the binary gas diffusivity block.
// It depends on bgd_pkg and binary_gas_diffusivity and predicts every result internally.
`default_nettype none

module binary_gas_diffusivity_tb;
    import bgd_pkg::*;

    localparam int FRAC_BITS   = 40;
    localparam int DRAIN_WAIT  = 120;     // Waits beyond the pipeline depth, with a margin.
    localparam int CYCLE_LIMIT = 600000;

    // Fixed-point tables of the predictor: log2(1+k/16) and 2^-(k/16), both in Q16.
    localparam logic [16:0] LOG2_Q16 [17] = '{0, 5732, 11136, 16248, 21098, 25711,
        30109, 34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    localparam logic [16:0] POW2N_Q16 [17] = '{65536, 62757, 60097, 57549, 55109,
        52772, 50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    // Well depth times 256 and the species constant in Q32, for nh3, n2, h2 and o2.
    localparam logic [15:0] WELL_Q8 [4] = '{47442, 18278, 16714, 22345};
    localparam logic [22:0] SPECIES_K [4] = '{1717899, 1478163, 5303197, 1564809};
    // Neufeld collision integral coefficients in Q16.
    localparam logic [63:0] CI_A = 69492, CI_B = 10230, CI_C = 12648, CI_E = 67887;
    localparam logic [63:0] CI_G = 115654, CI_DL = 45038, CI_FL = 144655, CI_HL = 368178;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_OPERATING_PRESSURE;
    logic [23:0] i_cfg_data = '0;

    binary_gas_diffusivity #(.OUTPUT_FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copies of the two configuration registers.
    logic [23:0] op_pressure = OP_PRESSURE_RESET;
    logic [15:0] supp_zone = SUPP_ZONE_RESET;

    t_out expected_diff_q[$];
    int   mismatches = 0;
    int   cells_sent = 0;
    int   results_seen = 0;
    int   burst_left = 0;
    longint unsigned cycles = 0;

    // Floor of the square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] root, bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= root + bit_w) begin
                v -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    // log2 in Q16 by table lookup with linear interpolation on the low 12 bits.
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int n;
        logic [63:0] frac, idx, low;
        if (x < 65536) x = 65536;
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        frac = (x >> (n - 16)) - 65536;
        idx = (frac >> 12) & 15;
        low = frac & 64'hFFF;
        return (64'(n - 16) << 16) + LOG2_Q16[idx]
             + ((64'(LOG2_Q16[idx + 1] - LOG2_Q16[idx]) * low) >> 12);
    endfunction

    // 2^-y for y in Q16; zero once the integer part reaches 32.
    function automatic logic [63:0] pow2_neg(input logic [63:0] y);
        logic [63:0] ip, idx, low, mant;
        ip = y >> 16;
        if (ip >= 32) return 0;
        idx = (y >> 12) & 15;
        low = y & 64'hFFF;
        mant = POW2N_Q16[idx]
             - ((64'(POW2N_Q16[idx] - POW2N_Q16[idx + 1]) * low) >> 12);
        return mant >> ip;
    endfunction

    function automatic logic [63:0] collision_integral(input logic [63:0] ts);
        logic [63:0] om;
        om  = (CI_A * pow2_neg((CI_B * log2_fixed(ts)) >> 16)) >> 16;
        om += (CI_C * pow2_neg((CI_DL * ts) >> 16)) >> 16;
        om += (CI_E * pow2_neg((CI_FL * ts) >> 16)) >> 16;
        om += (CI_G * pow2_neg((CI_HL * ts) >> 16)) >> 16;
        if (om < 1) om = 1;
        if (om > 131071) om = 131071;
        return om;
    endfunction

    // Diffusivity of one cell under the current register settings.
    function automatic t_out predict_diffusivity(input t_in item);
        t_out res;
        longint pabs;
        logic [63:0] t16, t15, ts, om, num, den, quo, rem;
        pabs = longint'(item.gauge_pressure) + longint'(op_pressure);
        t16 = 64'(item.temperature);
        if (item.zone_id == supp_zone) begin
            res.diffusivity = '0;
            res.source = SRC_SUPPRESSED;
        end else if (t16 < 4800 || t16 > 80000 || pabs < 10000 || item.species > 3) begin
            res.diffusivity = DIFF_W'(((64'd2 << FRAC_BITS) + 5000) / 10000);
            res.source = SRC_FALLBACK;
        end else begin
            t15 = t16 * isqrt64(t16 << 20);
            ts = (t16 << 20) / WELL_Q8[item.species[1:0]];
            om = collision_integral(ts);
            num = SPECIES_K[item.species[1:0]] * t15;
            den = 64'(pabs) * om;
            quo = num / den;
            rem = num % den;
            // Extend the quotient to the output fraction bits, then round half up.
            for (int i = 32; i < FRAC_BITS; i++) begin
                rem <<= 1;
                quo <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    quo |= 1;
                end
            end
            if ((rem << 1) >= den) quo++;
            if (quo > 64'(DIFF_MAX)) quo = 64'(DIFF_MAX);
            res.diffusivity = quo[DIFF_W-1:0];
            res.source = SRC_COMPUTED;
        end
        return res;
    endfunction

    // Receiver stall pattern: the mode steps in turn through never stalling,
    // random stalls, mostly stalled and rarely stalled.
    always @(posedge i_clk) begin
        case ((cycles >> 6) % 4)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 1);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Result checker: every accepted transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out exp_res;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_diff_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: diffusivity %0d source %0d",
                             o_out_data.diffusivity, o_out_data.source);
            end else begin
                exp_res = expected_diff_q.pop_front();
                if (o_out_data.diffusivity !== exp_res.diffusivity ||
                    o_out_data.source !== exp_res.source) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected diffusivity %0d source %0d, got %0d %0d",
                                 exp_res.diffusivity, exp_res.source,
                                 o_out_data.diffusivity, o_out_data.source);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Sends one cell. The sender works in bursts; a gap of random length
    // separates consecutive bursts, and some gaps are zero.
    task automatic send_cell(input t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_diff_q.push_back(predict_diffusivity(item));
        cells_sent++;
        burst_left--;
    endtask

    // Lets the pipeline empty: every prediction must come back before returning.
    task automatic drain;
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_diff_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Writes one register; only called while the pipeline is empty. The
    // enable is dropped after the write edge and the task waits for the next edge, so back-to-back writes never
    // schedule two updates of it in the same time step.
    task automatic write_cfg(input logic index, input logic [23:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_OPERATING_PRESSURE) op_pressure = value;
        else supp_zone = value[15:0];
        @(posedge i_clk);
    endtask

    function automatic t_in make_cell(input logic [15:0] zone, input logic [2:0] sp,
                                      input logic [19:0] temp, input logic [31:0] gauge);
        t_in c;
        c.zone_id = zone;
        c.species = sp;
        c.temperature = temp;
        c.gauge_pressure = gauge;
        return c;
    endfunction

    // A random cell: mostly trusted inputs that take the computed path, the
    // rest suppressed zone, window edges, low pressure, unknown species and raw noise.
    function automatic t_in random_cell();
        t_in c;
        int kind;
        kind = $urandom_range(0, 99);
        c.zone_id = 16'($urandom_range(0, 65535));
        if (c.zone_id == supp_zone) c.zone_id = c.zone_id + 16'd1;
        c.species = 3'($urandom_range(0, 3));
        c.temperature = 20'($urandom_range(4800, 80000));
        c.gauge_pressure = 32'($urandom_range(0, 2000000)) - 32'(op_pressure) + 32'sd10000;
        if (kind < 8) begin
            c.zone_id = supp_zone;
        end else if (kind < 14) begin
            c.temperature = ($urandom_range(0, 1) == 1) ? 20'($urandom_range(4790, 4810))
                                                         : 20'($urandom_range(79990, 80010));
        end else if (kind < 20) begin
            c.gauge_pressure = 32'sd10000 - 32'(op_pressure) + 32'($urandom_range(0, 4)) - 2;
        end else if (kind < 24) begin
            c.species = 3'($urandom_range(4, 7));
        end else if (kind < 34) begin
            c.zone_id = 16'($urandom);
            c.species = 3'($urandom);
            c.temperature = 20'($urandom);
            c.gauge_pressure = $urandom;
        end
        return c;
    endfunction

    // Field extremes, every species and every special case at reset settings.
    task automatic test_directed;
        logic [31:0] at_min;
        at_min = 32'sd10000 - 32'(op_pressure);
        send_cell(make_cell(16'd6, 3'd2, 20'd20000, 32'd0));           // suppressed zone
        send_cell(make_cell(16'd6, 3'd7, 20'hFFFFF, 32'h8000_0000));    // suppressed overrides rest
        for (int sp = 0; sp < 8; sp++)
            send_cell(make_cell(16'd1, 3'(sp), 20'd32000, 32'd0));     // every species
        send_cell(make_cell(16'd0, 3'd0, 20'd0, 32'd0));                // coldest
        send_cell(make_cell(16'd0, 3'd0, 20'd4799, 32'd0));             // just below the window
        send_cell(make_cell(16'd0, 3'd0, 20'd4800, 32'd0));             // window edges
        send_cell(make_cell(16'd0, 3'd2, 20'd80000, 32'd0));
        send_cell(make_cell(16'd0, 3'd2, 20'd80001, 32'd0));
        send_cell(make_cell(16'hFFFF, 3'd1, 20'hFFFFF, 32'd0));
        send_cell(make_cell(16'd0, 3'd2, 20'd80000, at_min));          // lowest trusted pressure
        send_cell(make_cell(16'd0, 3'd2, 20'd80000, at_min - 1));      // just below it
        send_cell(make_cell(16'd0, 3'd3, 20'd4800, 32'h7FFF_FFFF));     // highest pressure
        send_cell(make_cell(16'd0, 3'd3, 20'd4800, 32'h8000_0000));     // negative absolute pressure
        drain();
    endtask

    // Register extremes, each followed by cells that exercise them.
    task automatic test_config_sweep;
        logic [23:0] op_set [4] = '{24'd0, 24'hFFFFFF, 24'd10000, 24'd100000};
        logic [15:0] zone_set [4] = '{16'd0, 16'hFFFF, 16'h5A5A, 16'd6};
        for (int s = 0; s < 4; s++) begin
            write_cfg(CFG_OPERATING_PRESSURE, op_set[s]);
            write_cfg(CFG_SUPPRESSED_ZONE, 24'(zone_set[s]));
            send_cell(make_cell(zone_set[s], 3'd0, 20'd40000, 32'd0));
            send_cell(make_cell(zone_set[s] ^ 16'd1, 3'd2, 20'd80000, 32'sd10000 - 32'(op_set[s])));
            repeat (30) send_cell(random_cell());
            drain();
        end
    endtask

    // Long random phases with fresh register values between them.
    task automatic test_random;
        for (int phase = 0; phase < 8; phase++) begin
            write_cfg(CFG_OPERATING_PRESSURE, (phase % 2 == 0) ? 24'($urandom_range(0, 300000))
                                                                : 24'($urandom));
            write_cfg(CFG_SUPPRESSED_ZONE, 24'($urandom_range(0, 65535)));
            repeat (210) send_cell(random_cell());
            drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random();
        foreach (expected_diff_q[i]) ;
        $display("Covered %0d cells and %0d results across reset, extreme and random settings.",
                 cells_sent, results_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/bgd_pkg.sv
design/bgd_omega.sv
design/binary_gas_diffusivity.sv
tb/sv/binary_gas_diffusivity_tb.sv
